/* rtl/dtu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtu_pkg
// Shared types, codes and constant tables for the duration text parser.
// ----------------------------------------------------------------------------
package dtu_pkg;

	typedef enum logic [1:0] {
		PH_BETWEEN,
		PH_NUMBER,
		PH_SUFFIX
	} phase_t;

	typedef enum logic [2:0] {
		U_US,
		U_MS,
		U_SEC,
		U_MIN,
		U_HR
	} unit_t;

	typedef enum logic [2:0] {
		BS_IDLE,
		BS_MUL,
		BS_DIV,
		BS_TERM,
		BS_SUM,
		BS_EMIT
	} bstate_t;

	localparam int UNIT_W      = $bits(unit_t);
	localparam int QUEUE_DEPTH = 4;
	localparam int MUL_STEPS   = 4;
	localparam int DIV_STEPS   = 32;

	// characters
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LOWER = 8'h20;

	// lower-case suffix spellings, last letter in the low byte
	localparam logic [23:0] SFX_H   = 24'h000068;
	localparam logic [23:0] SFX_US  = 24'h007573;
	localparam logic [23:0] SFX_MS  = 24'h006D73;
	localparam logic [23:0] SFX_HR  = 24'h006872;
	localparam logic [23:0] SFX_MIN = 24'h6D696E;

	localparam logic [2:0] SLEN_MAX = 3'd7;

	function automatic int frac_width(int fd);
		return (fd * 10) / 3 + 1;
	endfunction

	function automatic int digit_width(int fd);
		return $clog2(fd + 1);
	endfunction

	// queue entry: fin, has_term, int_ovf, unit, ndig, frac, integer
	function automatic int entry_width(int fd, int tw);
		return 3 + UNIT_W + digit_width(fd) + frac_width(fd) + tw;
	endfunction

	function automatic unit_t unit_of(logic [23:0] s, logic [2:0] n);
		unit_t u;
		u = U_SEC;
		if (n == 3'd1 && s == SFX_H)
			u = U_HR;
		else if (n == 3'd2 && s == SFX_US)
			u = U_US;
		else if (n == 3'd2 && s == SFX_MS)
			u = U_MS;
		else if (n == 3'd2 && s == SFX_HR)
			u = U_HR;
		else if (n == 3'd3 && s == SFX_MIN)
			u = U_MIN;
		return u;
	endfunction

	function automatic logic [31:0] unit_mult(unit_t u);
		logic [31:0] m;
		unique case (u)
			U_US:    m = 32'd1;
			U_MS:    m = 32'd1000;
			U_SEC:   m = 32'd1000000;
			U_MIN:   m = 32'd60000000;
			U_HR:    m = 32'd3600000000;
			default: m = 32'd1000000;
		endcase
		return m;
	endfunction

	function automatic logic [63:0] pow10(logic [3:0] n);
		logic [63:0] p;
		unique case (n)
			4'd0:  p = 64'd1;
			4'd1:  p = 64'd10;
			4'd2:  p = 64'd100;
			4'd3:  p = 64'd1000;
			4'd4:  p = 64'd10000;
			4'd5:  p = 64'd100000;
			4'd6:  p = 64'd1000000;
			4'd7:  p = 64'd10000000;
			4'd8:  p = 64'd100000000;
			4'd9:  p = 64'd1000000000;
			4'd10: p = 64'd10000000000;
			4'd11: p = 64'd100000000000;
			4'd12: p = 64'd1000000000000;
			4'd13: p = 64'd10000000000000;
			4'd14: p = 64'd100000000000000;
			4'd15: p = 64'd1000000000000000;
		endcase
		return p;
	endfunction

endpackage
`default_nettype wire

/* rtl/dtu_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtu_in_if
// Byte channel: one character of the duration text per request.
// ----------------------------------------------------------------------------
interface dtu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       last;

	modport source (output valid, output character, output last, input ready);
	modport sink   (input valid, input character, input last, output ready);
endinterface
`default_nettype wire

/* rtl/dtu_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtu_out_if
// Result channel: summed duration in microseconds and saturation flag.
// ----------------------------------------------------------------------------
interface dtu_out_if;
	logic        valid;
	logic        ready;
	logic [62:0] duration_us;
	logic        saturated;

	modport source (output valid, output duration_us, output saturated, input ready);
	modport sink   (input valid, input duration_us, input saturated, output ready);
endinterface
`default_nettype wire

/* rtl/dtu_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtu_front
// Byte classifier: builds the open term and pushes closed terms to the queue.
// ----------------------------------------------------------------------------
module dtu_front import dtu_pkg::*; #(
	parameter int FRAC_DIGITS = 12,
	parameter int TOTAL_WIDTH = 63
) (
	input  logic                 clk,
	input  logic                 arst_n,
	dtu_in_if.sink               text,
	input  logic                 full,
	output logic                 push,
	output logic [entry_width(FRAC_DIGITS, TOTAL_WIDTH)-1:0] push_data
);

	localparam int FW = frac_width(FRAC_DIGITS);
	localparam int DW = digit_width(FRAC_DIGITS);
	localparam int TW = TOTAL_WIDTH;
	localparam logic [TW-1:0] TMAX = '1;

	typedef struct packed {
		logic            fin;
		logic            has_term;
		logic            int_ovf;
		unit_t           unit;
		logic [DW-1:0]   ndig;
		logic [FW-1:0]   frac;
		logic [TW-1:0]   int_part;
	} qent_t;

	phase_t        phase_q, n_phase, p1;
	logic          dot_q, n_dot, b_dot;
	logic [TW-1:0] int_q, n_int, b_int;
	logic [FW-1:0] frac_q, n_frac, b_frac;
	logic [DW-1:0] ndig_q, n_ndig, b_ndig;
	logic [23:0]   sfx_q, n_sfx, b_sfx;
	logic [2:0]    slen_q, n_slen, b_slen;
	logic          iovf_q, n_iovf, b_iovf;
	logic          pend_q;

	logic [7:0]    c;
	logic          nz, digit, dotc, letter, accept, commit1, start, numstep, sfxstep;
	logic [3:0]    dval;
	logic [TW+3:0] int_wide;
	logic [FW+3:0] frac_wide;
	logic          use_old;
	qent_t         ent;

	assign c      = text.character;
	assign nz     = (c != CH_NUL);
	assign digit  = (c >= CH_0) && (c <= CH_9);
	assign dotc   = (c == CH_DOT);
	assign letter = ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
	assign dval   = 4'(c - CH_0);

	assign text.ready = !pend_q && !full;
	assign accept     = text.valid && text.ready;

	always_comb begin
		commit1 = nz && (((phase_q == PH_NUMBER) && !(digit || (dotc && !dot_q)) && !letter)
		                 || ((phase_q == PH_SUFFIX) && !letter));
		if (commit1)
			p1 = PH_BETWEEN;
		else if (phase_q == PH_NUMBER && nz && letter)
			p1 = PH_SUFFIX;
		else
			p1 = phase_q;

		b_dot  = commit1 ? 1'b0 : dot_q;
		b_int  = commit1 ? '0 : int_q;
		b_frac = commit1 ? '0 : frac_q;
		b_ndig = commit1 ? '0 : ndig_q;
		b_sfx  = commit1 ? '0 : sfx_q;
		b_slen = commit1 ? '0 : slen_q;
		b_iovf = commit1 ? 1'b0 : iovf_q;

		start   = nz && (p1 == PH_BETWEEN) && (digit || dotc);
		numstep = nz && ((p1 == PH_NUMBER) || start);
		sfxstep = nz && (p1 == PH_SUFFIX);
		n_phase = start ? PH_NUMBER : p1;

		int_wide  = ({4'b0, b_int} << 3) + ({4'b0, b_int} << 1) + (TW+4)'(dval);
		frac_wide = ({4'b0, b_frac} << 3) + ({4'b0, b_frac} << 1) + (FW+4)'(dval);

		n_dot  = b_dot | (numstep && dotc);
		n_int  = b_int;
		n_frac = b_frac;
		n_ndig = b_ndig;
		n_iovf = b_iovf;
		if (numstep && !dotc) begin
			if (b_dot) begin
				if (b_ndig < DW'(FRAC_DIGITS)) begin
					n_frac = frac_wide[FW-1:0];
					n_ndig = b_ndig + 1'b1;
				end
			end else if (int_wide[TW+3:TW] != '0) begin
				n_int  = TMAX;
				n_iovf = 1'b1;
			end else begin
				n_int = int_wide[TW-1:0];
			end
		end

		n_sfx  = sfxstep ? {b_sfx[15:0], c | CH_LOWER} : b_sfx;
		n_slen = (sfxstep && b_slen != SLEN_MAX) ? b_slen + 3'd1 : b_slen;
	end

	// a closed term comes from the registers; the end of text takes the updated term
	always_comb begin
		use_old = pend_q || commit1;
		ent.fin      = pend_q || text.last && !(commit1 && n_phase != PH_BETWEEN);
		ent.has_term = use_old || (n_phase != PH_BETWEEN);
		ent.int_ovf  = use_old ? iovf_q : n_iovf;
		ent.unit     = use_old ? unit_of(sfx_q, slen_q) : unit_of(n_sfx, n_slen);
		ent.ndig     = use_old ? ndig_q : n_ndig;
		ent.frac     = use_old ? frac_q : n_frac;
		ent.int_part = use_old ? int_q : n_int;
		push      = pend_q ? !full : (accept && (commit1 || text.last));
		push_data = ent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BETWEEN;
			dot_q   <= 1'b0;
			int_q   <= '0;
			frac_q  <= '0;
			ndig_q  <= '0;
			sfx_q   <= '0;
			slen_q  <= '0;
			iovf_q  <= 1'b0;
			pend_q  <= 1'b0;
		end else if ((pend_q && !full) || (accept && text.last
		             && !(commit1 && n_phase != PH_BETWEEN))) begin
			phase_q <= PH_BETWEEN;
			dot_q   <= 1'b0;
			int_q   <= '0;
			frac_q  <= '0;
			ndig_q  <= '0;
			sfx_q   <= '0;
			slen_q  <= '0;
			iovf_q  <= 1'b0;
			pend_q  <= 1'b0;
		end else if (accept) begin
			phase_q <= n_phase;
			dot_q   <= n_dot;
			int_q   <= n_int;
			frac_q  <= n_frac;
			ndig_q  <= n_ndig;
			sfx_q   <= n_sfx;
			slen_q  <= n_slen;
			iovf_q  <= n_iovf;
			// last byte closed one term and opened another: second push held pending
			pend_q  <= text.last;
		end
	end

endmodule
`default_nettype wire

/* rtl/dtu_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtu_queue
// Small register FIFO between the byte classifier and the term arithmetic.
// ----------------------------------------------------------------------------
module dtu_queue import dtu_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head,
	output logic             full,
	output logic             empty
);

	localparam int PW = $clog2(DEPTH);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [PW:0]      cnt_q;

	assign full  = (cnt_q == (PW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full)
			slot_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full)
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop && !empty)
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push && !full) - (PW+1)'(pop && !empty);
		end
	end

endmodule
`default_nettype wire

/* rtl/dtu_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtu_back
// Term arithmetic: value times unit in fixed point, saturating running sum.
// ----------------------------------------------------------------------------
module dtu_back import dtu_pkg::*; #(
	parameter int FRAC_DIGITS = 12,
	parameter int TOTAL_WIDTH = 63
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [entry_width(FRAC_DIGITS, TOTAL_WIDTH)-1:0] head,
	input  logic                 empty,
	output logic                 pop,
	dtu_out_if.source            result
);

	localparam int FW = frac_width(FRAC_DIGITS);
	localparam int DW = digit_width(FRAC_DIGITS);
	localparam int TW = TOTAL_WIDTH;
	localparam logic [TW-1:0] TMAX = '1;

	typedef struct packed {
		logic            fin;
		logic            has_term;
		logic            int_ovf;
		unit_t           unit;
		logic [DW-1:0]   ndig;
		logic [FW-1:0]   frac;
		logic [TW-1:0]   int_part;
	} qent_t;

	bstate_t       state_q, state_d;
	qent_t         hd, ent_q;
	logic [4:0]    cnt_q;
	logic [63:0]   prod_q;
	logic [95:0]   ip_q, fp_q, fp_acc;
	logic [63:0]   r_q;
	logic [31:0]   sh_q;
	logic [TW-1:0] term_q, total_q, out_total_q;
	logic          ovf_q, out_sat_q, out_vld_q;
	logic          out_free, load_out;

	logic [63:0]   int64, frac64, dvsr;
	logic [31:0]   mul_a, mult;
	logic [64:0]   r1, r1_sub;
	logic          ge;
	logic [96:0]   term_full;
	logic [TW:0]   sum;

	assign hd       = head;
	assign out_free = !out_vld_q || result.ready;

	assign result.valid       = out_vld_q;
	assign result.duration_us = 63'(out_total_q);
	assign result.saturated   = out_sat_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BS_IDLE: if (!empty) state_d = hd.has_term ? BS_MUL : BS_EMIT;
			BS_MUL:  if (cnt_q == 5'(MUL_STEPS)) state_d = BS_DIV;
			BS_DIV:  if (cnt_q == 5'(DIV_STEPS - 1)) state_d = BS_TERM;
			BS_TERM: state_d = BS_SUM;
			BS_SUM:  state_d = ent_q.fin ? BS_EMIT : BS_IDLE;
			BS_EMIT: if (out_free) state_d = BS_IDLE;
			default: state_d = BS_IDLE;
		endcase
	end

	always_comb begin
		pop      = (state_q == BS_IDLE) && !empty;
		load_out = (state_q == BS_EMIT) && out_free;
	end

	// one 32x32 multiplier shared over the four halves of integer and fraction
	always_comb begin
		int64  = 64'(ent_q.int_part);
		frac64 = 64'(ent_q.frac);
		mult   = unit_mult(ent_q.unit);
		case (cnt_q[1:0])
			2'd0:    mul_a = int64[31:0];
			2'd1:    mul_a = int64[63:32];
			2'd2:    mul_a = frac64[31:0];
			default: mul_a = frac64[63:32];
		endcase
		fp_acc = fp_q + {prod_q, 32'b0};

		// restoring division of frac*mult by 10^ndig, one quotient bit a step
		dvsr   = pow10(4'(ent_q.ndig));
		r1     = {r_q, sh_q[31]};
		ge     = (r1 >= {1'b0, dvsr});
		r1_sub = r1 - {1'b0, dvsr};

		term_full = {1'b0, ip_q} + 97'(sh_q);
		sum       = {1'b0, total_q} + {1'b0, term_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BS_IDLE;
			cnt_q     <= '0;
			total_q   <= '0;
			ovf_q     <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out)
				out_vld_q <= 1'b1;
			else if (result.ready)
				out_vld_q <= 1'b0;
			unique case (state_q)
				BS_IDLE: begin
					cnt_q <= '0;
					if (pop)
						ovf_q <= ovf_q | hd.int_ovf;
				end
				BS_MUL:  cnt_q <= (cnt_q == 5'(MUL_STEPS)) ? '0 : cnt_q + 5'd1;
				BS_DIV:  cnt_q <= cnt_q + 5'd1;
				BS_TERM: if (term_full[96:TW] != '0) ovf_q <= 1'b1;
				BS_SUM: begin
					if (sum[TW]) begin
						total_q <= TMAX;
						ovf_q   <= 1'b1;
					end else begin
						total_q <= sum[TW-1:0];
					end
				end
				BS_EMIT: begin
					if (load_out) begin
						total_q <= '0;
						ovf_q   <= 1'b0;
					end
				end
				default: cnt_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			ent_q <= hd;
		if (load_out) begin
			out_total_q <= total_q;
			out_sat_q   <= ovf_q;
		end
		case (state_q)
			BS_MUL: begin
				prod_q <= {32'b0, mul_a} * {32'b0, mult};
				case (cnt_q)
					5'd1: ip_q <= {32'b0, prod_q};
					5'd2: ip_q <= ip_q + {prod_q, 32'b0};
					5'd3: fp_q <= {32'b0, prod_q};
					5'd4: begin
						// fraction < 10^ndig, so the quotient fits in 32 bits
						r_q  <= fp_acc[95:32];
						sh_q <= fp_acc[31:0];
					end
					default: ;
				endcase
			end
			BS_DIV: begin
				r_q  <= ge ? r1_sub[63:0] : r1[63:0];
				sh_q <= {sh_q[30:0], ge};
			end
			BS_TERM: term_q <= (term_full[96:TW] != '0) ? TMAX : term_full[TW-1:0];
			default: ;
		endcase
	end

endmodule
`default_nettype wire

/* rtl/duration_text_to_microseconds.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// duration_text_to_microseconds
// Parses a duration text such as "1h 30min 2.5s" byte by byte and returns the
// saturating total in microseconds after the last byte is taken.
//
//   channel   dir   payload                  request
//   text      in    character, last          one byte of the text
//   result    out   duration_us, saturated   one per text, after the last byte
//
// Bytes are taken one per cycle while the term queue has room. The back end
// takes one term at a time: pop, 5 multiply steps on one 32x32 multiplier,
// 32 restoring divide steps, term, sum, and an emit after the last term. A
// last byte that closes a term and opens another holds text until the second
// is pushed. Reset clears control and sum flops; there is no clearing pass.
// A stalled result register stalls the back end, then the queue, then text.
// ----------------------------------------------------------------------------
module duration_text_to_microseconds import dtu_pkg::*; #(
	parameter int FRAC_DIGITS = 12,
	parameter int TOTAL_WIDTH = 63
) (
	input  logic       clk,
	input  logic       arst_n,
	dtu_in_if.sink     text,
	dtu_out_if.source  result
);

	localparam int QW = entry_width(FRAC_DIGITS, TOTAL_WIDTH);

	logic          push, pop, full, empty;
	logic [QW-1:0] push_data, head;

	dtu_front #(
		.FRAC_DIGITS (FRAC_DIGITS),
		.TOTAL_WIDTH (TOTAL_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.text      (text),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	dtu_queue #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.full      (full),
		.empty     (empty)
	);

	dtu_back #(
		.FRAC_DIGITS (FRAC_DIGITS),
		.TOTAL_WIDTH (TOTAL_WIDTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

endmodule
`default_nettype wire
